@@ hw/rtl/pcd_pkg.sv @@
package pcd_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

   localparam int OPW  = 35;
   localparam int XW   = 54;
   localparam int ZW   = 35;
   localparam int ACCW = 63;

   localparam logic signed [ZW-1:0] PI_Q30     = 35'sd3373259426;
   localparam logic signed [17:0]   PI_Q13     = 18'sd25736;
   localparam logic signed [17:0]   TWO_PI_Q13 = 18'sd51472;

   typedef enum logic [2:0] {
      CSR_HEADING_GAIN_P = 3'd0,
      CSR_HEADING_GAIN_D = 3'd1,
      CSR_SPEED_GAIN_P   = 3'd2,
      CSR_SPEED_GAIN_D   = 3'd3,
      CSR_LOOP_RATE      = 3'd4,
      CSR_STANDOFF       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [OPW-1:0] num;
      logic signed [OPW-1:0] den;
      logic signed [32:0]    dx;
      logic signed [32:0]    dy;
   } job_type;

   typedef struct packed {
      logic [15:0] heading_gain_p;
      logic [15:0] heading_gain_d;
      logic [15:0] speed_gain_p;
      logic [15:0] speed_gain_d;
      logic [9:0]  loop_rate_hz;
      logic [23:0] standoff_distance;
   } cfg_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
      logic signed [31:0] r;
      if (v > $signed({{(ACCW-31){1'b0}}, 31'h7FFFFFFF})) begin
         r = 32'sh7FFFFFFF;
      end else if (v < $signed({{(ACCW-31){1'b1}}, 31'h0})) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/pcd_front.sv @@
module pcd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [31:0]   req_tracker_x,
   input  logic signed [31:0]   req_tracker_y,
   input  logic signed [15:0]   req_quat_w,
   input  logic signed [15:0]   req_quat_x,
   input  logic signed [15:0]   req_quat_y,
   input  logic signed [15:0]   req_quat_z,
   input  logic signed [31:0]   req_goal_x,
   input  logic signed [31:0]   req_goal_y,
   output logic                 job_push,
   input  logic                 job_full,
   output pcd_pkg::job_type     job_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM} state_type;

   state_type          state_ff, state_in;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [31:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   logic signed [32:0] s_num, s_den;

   assign req_full = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      job_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_push) begin
               state_in = ST_MUL;
               dx_in = {req_goal_x[31], req_goal_x} - {req_tracker_x[31], req_tracker_x};
               dy_in = {req_goal_y[31], req_goal_y} - {req_tracker_y[31], req_tracker_y};
            end
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: begin
            if (!job_full) begin
               job_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Products are 32-bit signed; their sums need one more bit.
   assign s_num = {p_wz_ff[31], p_wz_ff} + {p_xy_ff[31], p_xy_ff};
   assign s_den = {p_yy_ff[31], p_yy_ff} + {p_zz_ff[31], p_zz_ff};

   always_comb begin
      job_data.num = {{(pcd_pkg::OPW-34){s_num[32]}}, s_num, 1'b0};
      job_data.den = $signed(35'sd268435456)
                   - $signed({{(pcd_pkg::OPW-34){s_den[32]}}, s_den, 1'b0});
      job_data.dx  = dx_ff;
      job_data.dy  = dy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      if (state_ff == ST_IDLE && req_push) begin
         qw_ff <= req_quat_w;
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
      end
      if (state_ff == ST_MUL) begin
         p_wz_ff <= qw_ff * qz_ff;
         p_xy_ff <= qx_ff * qy_ff;
         p_yy_ff <= qy_ff * qy_ff;
         p_zz_ff <= qz_ff * qz_ff;
      end
   end

endmodule

@@ hw/rtl/pcd_queue.sv @@
module pcd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pcd_pkg::job_type wdata,
   input  logic             pop,
   output logic             empty,
   output pcd_pkg::job_type rdata
);

   pcd_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) entry_ff[wr_ptr_ff] <= wdata;
   end

endmodule

@@ hw/rtl/pcd_cordic.sv @@
module pcd_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pcd_pkg::OPW-1:0]   y_in,
   input  logic signed [pcd_pkg::OPW-1:0]   x_in,
   output logic                             done,
   output logic signed [15:0]               angle
);

   typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_ROUND} state_type;

   state_type                        state_ff;
   logic signed [pcd_pkg::XW-1:0]    x_ff, y_ff, xs, ys;
   logic signed [pcd_pkg::ZW-1:0]    z_ff, z_rnd, at;
   logic [4:0]                       step_ff;
   logic                             zero_ff;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign at = $signed({{(pcd_pkg::ZW-30){1'b0}}, pcd_pkg::atan_q30(step_ff)});
   assign z_rnd = z_ff + $signed(35'sd65536);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done     <= 1'b0;
      end else begin
         done <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_ITER;
                  step_ff  <= 5'd0;
                  zero_ff  <= (x_in == '0) && (y_in == '0);
                  if (x_in < 0) begin
                     z_ff <= (y_in >= 0) ? pcd_pkg::PI_Q30 : -pcd_pkg::PI_Q30;
                     x_ff <= -{{(pcd_pkg::XW-pcd_pkg::OPW-16){x_in[pcd_pkg::OPW-1]}},
                               x_in, 16'h0};
                     y_ff <= -{{(pcd_pkg::XW-pcd_pkg::OPW-16){y_in[pcd_pkg::OPW-1]}},
                               y_in, 16'h0};
                  end else begin
                     z_ff <= '0;
                     x_ff <= {{(pcd_pkg::XW-pcd_pkg::OPW-16){x_in[pcd_pkg::OPW-1]}},
                              x_in, 16'h0};
                     y_ff <= {{(pcd_pkg::XW-pcd_pkg::OPW-16){y_in[pcd_pkg::OPW-1]}},
                              y_in, 16'h0};
                  end
               end
            end
            ST_ITER: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(pcd_pkg::CORDIC_RUN - 1)) state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               done     <= 1'b1;
               state_ff <= ST_IDLE;
               // A zero vector has no direction and reads as angle zero.
               angle    <= zero_ff ? 16'sd0 : z_rnd[32:17];
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ hw/rtl/pcd_back.sv @@
module pcd_back (
   input  logic                clock,
   input  logic                reset,
   input  pcd_pkg::cfg_type    cfg,
   input  logic                job_empty,
   output logic                job_pop,
   input  pcd_pkg::job_type    job_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [31:0]  rsp_turn_rate,
   output logic signed [31:0]  rsp_forward_speed
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_YAW_GO, ST_YAW_WAIT, ST_BRG_GO, ST_BRG_WAIT, ST_SQ_X, ST_SQ_Y,
      ST_ROOT, ST_DERR, ST_T1, ST_T2, ST_T3, ST_F1, ST_F2, ST_F3, ST_DONE
   } state_type;

   state_type                         state_ff;
   pcd_pkg::job_type                  job_ff;
   logic                              cor_start, cor_done;
   logic signed [pcd_pkg::OPW-1:0]    cor_y, cor_x;
   logic signed [15:0]                cor_angle, yaw_ff, herr_ff, last_h_ff;
   logic signed [31:0]                derr_ff, last_d_ff;
   logic [32:0]                       ax, ay;
   logic                              far_ff;
   logic [63:0]                       sq_ff, v_ff, res_ff, bit_ff, trial;
   logic [4:0]                        root_cnt_ff;
   logic signed [17:0]                herr_raw, herr_w;
   logic signed [33:0]                derr_raw;
   logic signed [44:0]                mul_a, tmp_ff;
   logic signed [17:0]                mul_b;
   logic signed [pcd_pkg::ACCW-1:0]   prod, acc_t_ff, acc_f_ff, rnd_t, rnd_f;
   logic signed [31:0]                out_turn_ff [2];
   logic signed [31:0]                out_fwd_ff [2];
   logic                              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                        count_ff;
   logic                              do_push, do_pop;

   pcd_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .y_in  (cor_y),
      .x_in  (cor_x),
      .done  (cor_done),
      .angle (cor_angle)
   );

   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign cor_start = (state_ff == ST_YAW_GO) || (state_ff == ST_BRG_GO);
   assign cor_y     = (state_ff == ST_YAW_GO) ? job_ff.num
                    : {{(pcd_pkg::OPW-33){job_ff.dy[32]}}, job_ff.dy};
   assign cor_x     = (state_ff == ST_YAW_GO) ? job_ff.den
                    : {{(pcd_pkg::OPW-33){job_ff.dx[32]}}, job_ff.dx};

   assign ax = job_ff.dx[32] ? 33'(-job_ff.dx) : job_ff.dx;
   assign ay = job_ff.dy[32] ? 33'(-job_ff.dy) : job_ff.dy;

   // Heading error wraps into [-pi, pi]; one correction covers the whole range.
   assign herr_raw = {{2{cor_angle[15]}}, cor_angle} - {{2{yaw_ff[15]}}, yaw_ff};
   always_comb begin
      herr_w = herr_raw;
      if (herr_raw < -pcd_pkg::PI_Q13) begin
         herr_w = herr_raw + pcd_pkg::TWO_PI_Q13;
      end else if (herr_raw > pcd_pkg::PI_Q13) begin
         herr_w = herr_raw - pcd_pkg::TWO_PI_Q13;
      end
   end

   assign trial    = res_ff + bit_ff;
   assign derr_raw = $signed({1'b0, (far_ff ? 33'h0FFFFFFFF : res_ff[32:0])})
                   - $signed({10'h0, cfg.standoff_distance});

   // One shared multiplier serves all six products of the PD terms.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_T1: begin
            mul_a = 45'(herr_ff);
            mul_b = $signed({2'b0, cfg.heading_gain_p});
         end
         ST_T2: begin
            mul_a = 45'($signed({herr_ff[15], herr_ff}) - $signed({last_h_ff[15], last_h_ff}));
            mul_b = $signed({8'b0, cfg.loop_rate_hz});
         end
         ST_T3: begin
            mul_a = tmp_ff;
            mul_b = $signed({2'b0, cfg.heading_gain_d});
         end
         ST_F1: begin
            mul_a = 45'(derr_ff);
            mul_b = $signed({2'b0, cfg.speed_gain_p});
         end
         ST_F2: begin
            mul_a = 45'($signed({derr_ff[31], derr_ff}) - $signed({last_d_ff[31], last_d_ff}));
            mul_b = $signed({8'b0, cfg.loop_rate_hz});
         end
         ST_F3: begin
            mul_a = tmp_ff;
            mul_b = $signed({2'b0, cfg.speed_gain_d});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod  = mul_a * mul_b;
   assign rnd_t = (acc_t_ff + 63'sd16) >>> 5;
   assign rnd_f = (acc_f_ff + 63'sd128) >>> 8;

   assign do_push = (state_ff == ST_DONE) && (count_ff != 2'd2);
   assign do_pop  = rsp_pop && (count_ff != 2'd0);
   assign rsp_empty         = (count_ff == 2'd0);
   assign rsp_turn_rate     = out_turn_ff[rd_ptr_ff];
   assign rsp_forward_speed = out_fwd_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         last_h_ff <= '0;
         last_d_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
         case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  job_ff   <= job_data;
                  state_ff <= ST_YAW_GO;
               end
            end
            ST_YAW_GO: state_ff <= ST_YAW_WAIT;
            ST_YAW_WAIT: begin
               if (cor_done) begin
                  yaw_ff   <= cor_angle;
                  state_ff <= ST_BRG_GO;
               end
            end
            ST_BRG_GO: state_ff <= ST_BRG_WAIT;
            ST_BRG_WAIT: begin
               if (cor_done) begin
                  herr_ff  <= herr_w[15:0];
                  state_ff <= ST_SQ_X;
               end
            end
            ST_SQ_X: begin
               far_ff   <= ax[32] || ax[31] || ay[32] || ay[31];
               sq_ff    <= 64'(ax[30:0] * ax[30:0]);
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               v_ff        <= sq_ff + 64'(ay[30:0] * ay[30:0]);
               res_ff      <= '0;
               bit_ff      <= 64'h4000000000000000;
               root_cnt_ff <= 5'd0;
               state_ff    <= ST_ROOT;
            end
            ST_ROOT: begin
               if (v_ff >= trial) begin
                  v_ff   <= v_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff      <= bit_ff >> 2;
               root_cnt_ff <= root_cnt_ff + 5'd1;
               if (root_cnt_ff == 5'd31) state_ff <= ST_DERR;
            end
            ST_DERR: begin
               derr_ff  <= pcd_pkg::sat32(63'(derr_raw));
               state_ff <= ST_T1;
            end
            ST_T1: begin
               acc_t_ff <= prod;
               state_ff <= ST_T2;
            end
            ST_T2: begin
               tmp_ff   <= prod[44:0];
               state_ff <= ST_T3;
            end
            ST_T3: begin
               acc_t_ff <= acc_t_ff + prod;
               state_ff <= ST_F1;
            end
            ST_F1: begin
               acc_f_ff <= prod;
               state_ff <= ST_F2;
            end
            ST_F2: begin
               tmp_ff   <= prod[44:0];
               state_ff <= ST_F3;
            end
            ST_F3: begin
               acc_f_ff <= acc_f_ff + prod;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (count_ff != 2'd2) begin
                  last_h_ff <= herr_ff;
                  last_d_ff <= derr_ff;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (do_push) begin
         out_turn_ff[wr_ptr_ff] <= pcd_pkg::sat32(rnd_t);
         out_fwd_ff[wr_ptr_ff]  <= pcd_pkg::sat32(rnd_f);
      end
   end

endmodule

@@ hw/rtl/pursuit_pd_controller.sv @@
// Pursuit PD controller. Push one control tick word (tracker position,
// orientation quaternion, target position) on the req_ side while req_full
// is low; pop one word (turn_rate, forward_speed) from the rsp_ side while
// rsp_empty is low. The user must write gains, loop rate and standoff on
// the csr_ port only while the block is idle; the block does not enforce
// this. An unknown index is ignored. The front stage forms the yaw vector
// and the target offset in its idle, multiply and sum states and hands it
// through a two-word queue to the back stage. The back stage runs one
// shared iterative CORDIC twice, a 32-step square root, and six products
// on one multiplier. A result becomes visible on the rsp_ side in the
// cycle after the back stage pushes it; words are taken one at a time.
// Reset clears both stored errors to zero, loads the default gains and
// empties all queues. When the receiver stops popping, two results wait in
// the output queue, the back stage holds a third, the middle queue fills,
// and then req_full stays high until space opens again.
module pursuit_pd_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [31:0]  req_tracker_x,
   input  logic signed [31:0]  req_tracker_y,
   input  logic signed [15:0]  req_quat_w,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   input  logic signed [31:0]  req_goal_x,
   input  logic signed [31:0]  req_goal_y,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [31:0]  rsp_turn_rate,
   output logic signed [31:0]  rsp_forward_speed,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_wdata
);

   pcd_pkg::cfg_type cfg_ff;
   pcd_pkg::job_type front_job, queue_job;
   logic             job_push, job_full, job_pop, job_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heading_gain_p    <= 16'd256;
         cfg_ff.heading_gain_d    <= 16'd0;
         cfg_ff.speed_gain_p      <= 16'd256;
         cfg_ff.speed_gain_d      <= 16'd0;
         cfg_ff.loop_rate_hz      <= 10'd10;
         cfg_ff.standoff_distance <= 24'd65536;
      end else if (csr_write) begin
         case (csr_index)
            pcd_pkg::CSR_HEADING_GAIN_P: cfg_ff.heading_gain_p    <= csr_wdata[15:0];
            pcd_pkg::CSR_HEADING_GAIN_D: cfg_ff.heading_gain_d    <= csr_wdata[15:0];
            pcd_pkg::CSR_SPEED_GAIN_P:   cfg_ff.speed_gain_p      <= csr_wdata[15:0];
            pcd_pkg::CSR_SPEED_GAIN_D:   cfg_ff.speed_gain_d      <= csr_wdata[15:0];
            pcd_pkg::CSR_LOOP_RATE:      cfg_ff.loop_rate_hz      <= csr_wdata[9:0];
            pcd_pkg::CSR_STANDOFF:       cfg_ff.standoff_distance <= csr_wdata;
            default: ;
         endcase
      end
   end

   pcd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_tracker_x (req_tracker_x),
      .req_tracker_y (req_tracker_y),
      .req_quat_w    (req_quat_w),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_goal_x    (req_goal_x),
      .req_goal_y    (req_goal_y),
      .job_push      (job_push),
      .job_full      (job_full),
      .job_data      (front_job)
   );

   pcd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .full  (job_full),
      .wdata (front_job),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (queue_job)
   );

   pcd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .job_empty         (job_empty),
      .job_pop           (job_pop),
      .job_data          (queue_job),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_turn_rate     (rsp_turn_rate),
      .rsp_forward_speed (rsp_forward_speed)
   );

endmodule
